// ----- rtl/chtbl_pkg.sv -----
`timescale 1ns / 1ps

package chtbl_pkg;

    localparam int BUCKETS_DEF = 256;
    localparam int ENTRIES_DEF = 1024;

    localparam int CFG_W  = 9;
    localparam int KEY_W  = 64;
    localparam int VAL_W  = 64;
    localparam int HASH_W = 32;

    // The bucket remainder is formed DIV_BITS quotient bits per cycle.
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = HASH_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [HASH_W-1:0] PCG_MUL  = 32'd747796405;
    localparam logic [HASH_W-1:0] PCG_INC  = 32'd2891336453;
    localparam logic [HASH_W-1:0] PCG_MUL2 = 32'd277803737;

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_code_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_HASH3,
        ST_DIV,
        ST_HEAD,
        ST_HEADW,
        ST_WALK,
        ST_CMP,
        ST_POP,
        ST_INSERT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic hash1;
        logic hash2;
        logic hash3;
        logic div_step;
        logic head_take;
        logic walk_adv;
        logic hit_set;
        logic hit_remove;
        logic hit_get;
        logic take_pop;
        logic take_fresh;
        logic insert;
        logic set_full;
    } ctl_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      cur_nil;
        logic      key_match;
        logic      stack_empty;
        logic      fresh_avail;
        logic      clear_last;
    } sts_t;

endpackage

// ----- rtl/chtbl_ram.sv -----
`timescale 1ns / 1ps

module chtbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/chtbl_ctrl.sv -----
`timescale 1ns / 1ps

module chtbl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  chtbl_pkg::sts_t   sts,
    output chtbl_pkg::ctl_t   ctl,
    output logic              busy,
    output logic              result_valid
);

    chtbl_pkg::state_t state_reg, state_next;
    logic [chtbl_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= chtbl_pkg::ST_CLEAR;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        ctl          = '0;
        busy         = 1'b1;
        result_valid = 1'b0;
        case (state_reg)
            chtbl_pkg::ST_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = chtbl_pkg::ST_IDLE;
                end
            end
            chtbl_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = chtbl_pkg::ST_HASH1;
                end
            end
            chtbl_pkg::ST_HASH1:
            begin
                if (sts.cmd == chtbl_pkg::CMD_NOP)
                begin
                    state_next = chtbl_pkg::ST_DONE;
                end
                else
                begin
                    ctl.hash1  = 1'b1;
                    state_next = chtbl_pkg::ST_HASH2;
                end
            end
            chtbl_pkg::ST_HASH2:
            begin
                ctl.hash2  = 1'b1;
                state_next = chtbl_pkg::ST_HASH3;
            end
            chtbl_pkg::ST_HASH3:
            begin
                ctl.hash3    = 1'b1;
                div_cnt_next = '0;
                state_next   = chtbl_pkg::ST_DIV;
            end
            chtbl_pkg::ST_DIV:
            begin
                ctl.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == chtbl_pkg::DIV_CNT_W'(chtbl_pkg::DIV_STEPS - 1))
                begin
                    state_next = chtbl_pkg::ST_HEAD;
                end
            end
            chtbl_pkg::ST_HEAD:
            begin
                state_next = chtbl_pkg::ST_HEADW;
            end
            chtbl_pkg::ST_HEADW:
            begin
                ctl.head_take = 1'b1;
                state_next    = chtbl_pkg::ST_WALK;
            end
            chtbl_pkg::ST_WALK:
            begin
                if (!sts.cur_nil)
                begin
                    state_next = chtbl_pkg::ST_CMP;
                end
                else if (sts.cmd != chtbl_pkg::CMD_SET)
                begin
                    state_next = chtbl_pkg::ST_DONE;
                end
                else if (!sts.stack_empty)
                begin
                    state_next = chtbl_pkg::ST_POP;
                end
                else if (sts.fresh_avail)
                begin
                    ctl.take_fresh = 1'b1;
                    state_next     = chtbl_pkg::ST_INSERT;
                end
                else
                begin
                    ctl.set_full = 1'b1;
                    state_next   = chtbl_pkg::ST_DONE;
                end
            end
            chtbl_pkg::ST_CMP:
            begin
                if (sts.key_match)
                begin
                    state_next = chtbl_pkg::ST_DONE;
                    case (sts.cmd)
                        chtbl_pkg::CMD_SET:    ctl.hit_set    = 1'b1;
                        chtbl_pkg::CMD_REMOVE: ctl.hit_remove = 1'b1;
                        chtbl_pkg::CMD_GET:    ctl.hit_get    = 1'b1;
                        default:               ctl.hit_get    = 1'b0;
                    endcase
                end
                else
                begin
                    ctl.walk_adv = 1'b1;
                    state_next   = chtbl_pkg::ST_WALK;
                end
            end
            chtbl_pkg::ST_POP:
            begin
                ctl.take_pop = 1'b1;
                state_next   = chtbl_pkg::ST_INSERT;
            end
            chtbl_pkg::ST_INSERT:
            begin
                ctl.insert = 1'b1;
                state_next = chtbl_pkg::ST_DONE;
            end
            chtbl_pkg::ST_DONE:
            begin
                result_valid = 1'b1;
                state_next   = chtbl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = chtbl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/chtbl_dp.sv -----
`timescale 1ns / 1ps

module chtbl_dp #(
    parameter int BUCKETS = chtbl_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chtbl_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  chtbl_pkg::ctl_t             ctl,
    output chtbl_pkg::sts_t             sts,
    input  logic [1:0]                  command,
    input  logic [chtbl_pkg::KEY_W-1:0] key,
    input  logic [chtbl_pkg::VAL_W-1:0] value,
    input  logic                        cfg_wr,
    input  logic [chtbl_pkg::CFG_W-1:0] cfg_data,
    output logic                        found,
    output logic [chtbl_pkg::VAL_W-1:0] value_out,
    output logic                        status
);

    localparam int EW  = $clog2(ENTRIES);
    localparam int LW  = $clog2(ENTRIES + 1);
    localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NBW = $clog2(BUCKETS + 1);
    localparam int NW  = (NBW > chtbl_pkg::CFG_W) ? NBW : chtbl_pkg::CFG_W;
    localparam int HW  = chtbl_pkg::HASH_W;
    localparam logic [LW-1:0] NIL = LW'(ENTRIES);

    logic [NW-1:0]               n_reg;
    logic [chtbl_pkg::KEY_W-1:0] key_reg;
    logic [chtbl_pkg::VAL_W-1:0] val_reg;
    chtbl_pkg::cmd_code_t        cmd_reg;
    logic [HW-1:0]               sa_reg, sb_reg, wa_reg, wb_reg, q_reg;
    logic [NW:0]                 rem_reg;
    logic [BW-1:0]               clr_reg;
    logic [LW-1:0]               cur_reg, prev_reg, head_reg;
    logic [EW-1:0]               slot_reg;
    logic [LW-1:0]               top_reg, fresh_reg;
    logic                        found_reg, status_reg;
    logic [chtbl_pkg::VAL_W-1:0] vout_reg;

    logic [NW-1:0]  n_next;
    logic [NW:0]    rem_next;
    logic [HW-1:0]  q_next;
    logic [HW-1:0]  lo, mix, sa_sh, sb_sh, fa, fb;
    logic [BW-1:0]  bucket;

    logic [LW-1:0]               head_rdata, next_rdata;
    logic [chtbl_pkg::KEY_W-1:0] key_rdata;
    logic [chtbl_pkg::VAL_W-1:0] val_rdata;
    logic [EW-1:0]               stack_rdata;

    logic            head_we, val_we, next_we, stack_we;
    logic [BW-1:0]   head_waddr;
    logic [LW-1:0]   head_wdata, next_wdata;
    logic [EW-1:0]   val_waddr, next_waddr;
    logic [chtbl_pkg::VAL_W-1:0] val_wdata;
    logic [LW-1:0]   top_dec;
    logic            prev_nil;

    assign lo     = key_reg[HW-1:0];
    assign mix    = key_reg[HW-1:0] ^ key_reg[2*HW-1:HW];
    assign sa_sh  = sa_reg >> (5'(sa_reg[HW-1:HW-4]) + 5'd4);
    assign sb_sh  = sb_reg >> (5'(sb_reg[HW-1:HW-4]) + 5'd4);
    assign fa     = (wa_reg >> 22) ^ wa_reg;
    assign fb     = (wb_reg >> 22) ^ wb_reg;
    assign bucket = rem_reg[BW-1:0];
    assign top_dec  = top_reg - 1'b1;
    assign prev_nil = (prev_reg == NIL);

    // Zero buckets selects bucket 0; a count above the table size saturates.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            n_next = NW'(1);
        end
        else if (NW'(cfg_data) > NW'(BUCKETS))
        begin
            n_next = NW'(BUCKETS);
        end
        else
        begin
            n_next = NW'(cfg_data);
        end
    end

    // Restoring division: DIV_BITS quotient bits a cycle, only the remainder is kept.
    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        for (int i = 0; i < chtbl_pkg::DIV_BITS; i++)
        begin
            rem_next = {rem_next[NW-1:0], q_next[HW-1]};
            q_next   = {q_next[HW-2:0], 1'b0};
            if (rem_next >= {1'b0, n_reg})
            begin
                rem_next = rem_next - {1'b0, n_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= NW'(BUCKETS);
            clr_reg   <= '0;
            top_reg   <= '0;
            fresh_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                n_reg <= n_next;
            end
            if (ctl.clear_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctl.hit_remove)
            begin
                top_reg <= top_reg + 1'b1;
            end
            else if (ctl.take_pop)
            begin
                top_reg <= top_dec;
            end
            if (ctl.take_fresh)
            begin
                fresh_reg <= fresh_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg    <= key;
            val_reg    <= value;
            cmd_reg    <= chtbl_pkg::cmd_code_t'(command);
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
            vout_reg   <= '0;
        end
        if (ctl.hash1)
        begin
            sa_reg <= lo * chtbl_pkg::PCG_MUL + chtbl_pkg::PCG_INC;
            sb_reg <= mix * chtbl_pkg::PCG_MUL + chtbl_pkg::PCG_INC;
        end
        if (ctl.hash2)
        begin
            wa_reg <= (sa_sh ^ sa_reg) * chtbl_pkg::PCG_MUL2;
            wb_reg <= (sb_sh ^ sb_reg) * chtbl_pkg::PCG_MUL2;
        end
        if (ctl.hash3)
        begin
            q_reg   <= fa + fb;
            rem_reg <= '0;
        end
        if (ctl.div_step)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
        if (ctl.head_take)
        begin
            cur_reg  <= head_rdata;
            head_reg <= head_rdata;
            prev_reg <= NIL;
        end
        if (ctl.walk_adv)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= next_rdata;
        end
        if (ctl.take_pop)
        begin
            slot_reg <= stack_rdata;
        end
        if (ctl.take_fresh)
        begin
            slot_reg <= fresh_reg[EW-1:0];
        end
        if (ctl.hit_set || ctl.hit_remove)
        begin
            found_reg <= 1'b1;
        end
        if (ctl.hit_get)
        begin
            found_reg <= 1'b1;
            vout_reg  <= val_rdata;
        end
        if (ctl.set_full)
        begin
            status_reg <= 1'b1;
        end
    end

    always_comb
    begin
        head_we    = ctl.clear_wr || ctl.insert || (ctl.hit_remove && prev_nil);
        head_waddr = ctl.clear_wr ? clr_reg : bucket;
        head_wdata = ctl.clear_wr ? NIL : (ctl.insert ? LW'(slot_reg) : next_rdata);

        val_we     = ctl.hit_set || ctl.insert;
        val_waddr  = ctl.insert ? slot_reg : cur_reg[EW-1:0];
        val_wdata  = val_reg;

        next_we    = ctl.insert || (ctl.hit_remove && !prev_nil);
        next_waddr = ctl.insert ? slot_reg : prev_reg[EW-1:0];
        next_wdata = ctl.insert ? head_reg : next_rdata;

        stack_we   = ctl.hit_remove;
    end

    chtbl_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (bucket),
        .rdata (head_rdata)
    );

    chtbl_ram #(.WIDTH(chtbl_pkg::KEY_W), .DEPTH(ENTRIES)) u_key (
        .clk   (clk),
        .we    (ctl.insert),
        .waddr (slot_reg),
        .wdata (key_reg),
        .raddr (cur_reg[EW-1:0]),
        .rdata (key_rdata)
    );

    chtbl_ram #(.WIDTH(chtbl_pkg::VAL_W), .DEPTH(ENTRIES)) u_val (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (cur_reg[EW-1:0]),
        .rdata (val_rdata)
    );

    chtbl_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (cur_reg[EW-1:0]),
        .rdata (next_rdata)
    );

    chtbl_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_stack (
        .clk   (clk),
        .we    (stack_we),
        .waddr (top_reg[EW-1:0]),
        .wdata (cur_reg[EW-1:0]),
        .raddr (top_dec[EW-1:0]),
        .rdata (stack_rdata)
    );

    always_comb
    begin
        sts.cmd         = cmd_reg;
        sts.cur_nil     = (cur_reg == NIL);
        sts.key_match   = (key_rdata == key_reg);
        sts.stack_empty = (top_reg == '0);
        sts.fresh_avail = (fresh_reg < LW'(ENTRIES));
        sts.clear_last  = (clr_reg == BW'(BUCKETS - 1));
    end

    assign found     = found_reg;
    assign value_out = vout_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // Every freed slot was once handed out fresh, so the pool never overflows.
    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= fresh_reg)
        else $error("free stack deeper than slots handed out");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= LW'(ENTRIES))
        else $error("fresh slot counter beyond entry store");

    a_hit_live: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.hit_set || ctl.hit_remove || ctl.hit_get) |-> !sts.cur_nil)
        else $error("hit action on an empty link");

    a_full_only_set: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.set_full |-> (cmd_reg == chtbl_pkg::CMD_SET && top_reg == '0))
        else $error("store full reported outside a set with an empty pool");
`endif

endmodule

// ----- rtl/chained_hash_key_value_table_unit.sv -----
`timescale 1ns / 1ps

// Key to value table, 64-bit keys and values, hashed with separate chaining.
// Command channel: drive command, key and value with start; the word is taken
// at a rising edge where start is high and busy is low. Commands are set (insert
// or overwrite), remove and get; the unused code answers with all zeros.
// Result channel: found, value_out and status are valid for exactly one cycle
// while result_valid is high. The receiver cannot stall; it must take the word.
// Configuration: cfg_data carries the bucket count, written when cfg_valid and
// cfg_ready are both high; cfg_ready is always high. Write only while idle.
// Sequence from the accepting edge: hash and fold (HASH1 to HASH3), form the
// bucket remainder (four bits a cycle), fetch the bucket head, compare each
// chain entry in turn, see the end of the chain, and on a set that misses take
// a free slot and link it; then the result cycle. The unused code goes from
// HASH1 straight to the result cycle.
// One word is in flight at a time: busy falls in the cycle after the result cycle.
// Reset: the bucket head memory is swept to empty, one bucket a cycle, so busy
// stays high until every bucket has been cleared after reset is released.
module chained_hash_key_value_table_unit #(
    parameter int BUCKETS = chtbl_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chtbl_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  command,
    input  logic [chtbl_pkg::KEY_W-1:0] key,
    input  logic [chtbl_pkg::VAL_W-1:0] value,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [chtbl_pkg::CFG_W-1:0] cfg_data,
    output logic                        result_valid,
    output logic                        found,
    output logic [chtbl_pkg::VAL_W-1:0] value_out,
    output logic                        status
);

    chtbl_pkg::ctl_t ctl;
    chtbl_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    chtbl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .sts          (sts),
        .ctl          (ctl),
        .busy         (busy),
        .result_valid (result_valid)
    );

    chtbl_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .command   (command),
        .key       (key),
        .value     (value),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .found     (found),
        .value_out (value_out),
        .status    (status)
    );

endmodule

// ----- sim/chained_hash_key_value_table_checker.sv -----
`timescale 1ns / 1ps

module chained_hash_key_value_table_checker #(
    parameter int BUCKETS = chtbl_pkg::BUCKETS_DEF,
    parameter int ENTRIES = chtbl_pkg::ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [1:0]                  command,
    input  logic [chtbl_pkg::KEY_W-1:0] key,
    input  logic [chtbl_pkg::VAL_W-1:0] value,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [chtbl_pkg::CFG_W-1:0] cfg_data,
    input  logic                        result_valid,
    input  logic                        found,
    input  logic [chtbl_pkg::VAL_W-1:0] value_out,
    input  logic                        status,
    output int                          fail_count,
    output int                          pending_count
);

    typedef struct packed {
        logic                        found;
        logic [chtbl_pkg::VAL_W-1:0] value_out;
        logic                        status;
    } answer_t;

    localparam int NIL = ENTRIES;

    answer_t                     answer_q[$];
    logic [chtbl_pkg::CFG_W-1:0] divisor;
    int                          head_tbl[BUCKETS];
    logic [63:0]                 slot_key[ENTRIES];
    logic [63:0]                 slot_val[ENTRIES];
    int                          slot_next[ENTRIES];
    int                          free_pool[ENTRIES];
    int                          free_top;

    function automatic logic [31:0] pcg_mix(input logic [31:0] x);
        logic [31:0] s;
        logic [31:0] w;
        s = x * 32'd747796405 + 32'd2891336453;
        w = ((s >> (s[31:28] + 4)) ^ s) * 32'd277803737;
        return (w >> 22) ^ w;
    endfunction

    function automatic int bucket_of(input logic [63:0] k);
        logic [31:0] h;
        int          n;
        h = pcg_mix(k[31:0]) + pcg_mix(k[31:0] ^ k[63:32]);
        n = divisor;
        if (n == 0) n = 1;
        if (n > BUCKETS) n = BUCKETS;
        return int'(h % n);
    endfunction

    function automatic answer_t apply_command(input logic [1:0] c, input logic [63:0] k,
                                              input logic [63:0] v);
        answer_t r;
        int      b;
        int      cur;
        int      prev;
        int      hit;
        int      slot;
        r = '0;
        if (c == chtbl_pkg::CMD_NOP) return r;
        b = bucket_of(k);
        cur = head_tbl[b];
        prev = NIL;
        hit = NIL;
        for (int s = 0; s < ENTRIES && cur < NIL; s++)
        begin
            if (slot_key[cur] == k)
            begin
                hit = cur;
                break;
            end
            prev = cur;
            cur = slot_next[cur];
        end
        r.found = (hit != NIL);
        if (c == chtbl_pkg::CMD_SET)
        begin
            if (hit != NIL) slot_val[hit] = v;
            else if (free_top == 0) r.status = 1'b1;
            else
            begin
                free_top--;
                slot = free_pool[free_top];
                slot_key[slot] = k;
                slot_val[slot] = v;
                slot_next[slot] = head_tbl[b];
                head_tbl[b] = slot;
            end
        end
        else if (c == chtbl_pkg::CMD_REMOVE)
        begin
            if (hit != NIL)
            begin
                if (prev == NIL) head_tbl[b] = slot_next[hit];
                else slot_next[prev] = slot_next[hit];
                slot_next[hit] = NIL;
                free_pool[free_top] = hit;
                free_top++;
            end
        end
        else if (hit != NIL)
        begin
            r.value_out = slot_val[hit];
        end
        return r;
    endfunction

    assign pending_count = answer_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            answer_q.delete();
            fail_count <= 0;
            divisor = chtbl_pkg::CFG_W'(BUCKETS);
            for (int i = 0; i < BUCKETS; i++) head_tbl[i] = NIL;
            for (int i = 0; i < ENTRIES; i++)
            begin
                slot_key[i] = '0;
                slot_val[i] = '0;
                slot_next[i] = NIL;
                free_pool[i] = i;
            end
            free_top = ENTRIES;
        end
        else
        begin
            if (cfg_valid && cfg_ready) divisor = cfg_data;
            if (result_valid)
            begin
                got = '{found, value_out, status};
                if (answer_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errs++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        errs++;
                    end
                    if (got.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %h, got %h", want.value_out,
                               got.value_out);
                        errs++;
                    end
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errs++;
                    end
                end
            end
            if (start && !busy) answer_q.push_back(apply_command(command, key, value));
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- sim/chained_hash_key_value_table_unit_tb.sv -----
`timescale 1ns / 1ps

module chained_hash_key_value_table_unit_tb;

    localparam int WATCHDOG = 20000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [1:0]                  command = '0;
    logic [chtbl_pkg::KEY_W-1:0] key = '0;
    logic [chtbl_pkg::VAL_W-1:0] value = '0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [chtbl_pkg::CFG_W-1:0] cfg_data = '0;
    logic                        result_valid;
    logic                        found;
    logic [chtbl_pkg::VAL_W-1:0] value_out;
    logic                        status;
    int                          fail_count;
    int                          pending_count;
    int                          quiet_cycles = 0;
    int                          send_idle_pct = 17;
    logic [63:0]                 key_pool[16];

    always #5 clk = ~clk;

    chained_hash_key_value_table_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .key(key), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .found(found), .value_out(value_out),
        .status(status)
    );

    chained_hash_key_value_table_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .key(key), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .found(found), .value_out(value_out),
        .status(status), .fail_count(fail_count), .pending_count(pending_count)
    );

    // The watchdog counts cycles in which no word moves on any channel.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // The block stays busy after taking a word, through at least its HASH1 state and
    // its result state, so the extra falling edge at the start costs no throughput.
    task automatic send_word(input logic [1:0] c, input logic [63:0] k,
                             input logic [63:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        start <= 1'b1;
        command <= c;
        key <= k;
        value <= v;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_buckets(input logic [chtbl_pkg::CFG_W-1:0] n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= n;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly operations on a small key pool so that hits, chains and removals occur.
    task automatic random_words(input int count);
        logic [1:0]  c;
        logic [63:0] k;
        for (int i = 0; i < count; i++)
        begin
            c = $urandom_range(9) == 0 ? chtbl_pkg::CMD_NOP : 2'($urandom_range(2));
            k = $urandom_range(4) == 0 ? rand64() : key_pool[$urandom_range(15)];
            send_word(c, k, rand64());
        end
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++) key_pool[i] = rand64();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 0;
        send_word(chtbl_pkg::CMD_GET, 64'd0, 64'd0);
        send_word(chtbl_pkg::CMD_SET, 64'd0, '1);
        send_word(chtbl_pkg::CMD_SET, '1, 64'd0);
        send_word(chtbl_pkg::CMD_GET, 64'd0, 64'd0);
        send_word(chtbl_pkg::CMD_GET, '1, '1);
        send_word(chtbl_pkg::CMD_SET, 64'd0, 64'h5555_aaaa_5555_aaaa);
        send_word(chtbl_pkg::CMD_GET, 64'd0, 64'd0);
        send_word(chtbl_pkg::CMD_REMOVE, 64'd0, 64'd0);
        send_word(chtbl_pkg::CMD_REMOVE, 64'd0, 64'd0);
        send_word(chtbl_pkg::CMD_GET, 64'd0, 64'd0);
        send_word(chtbl_pkg::CMD_NOP, '1, '1);
        send_word(chtbl_pkg::CMD_REMOVE, '1, 64'd0);
        write_buckets(9'd0);
        for (int i = 0; i < 4; i++) send_word(chtbl_pkg::CMD_SET, key_pool[i], rand64());
        for (int i = 0; i < 4; i++) send_word(chtbl_pkg::CMD_GET, key_pool[i], 64'd0);
        send_word(chtbl_pkg::CMD_REMOVE, key_pool[1], 64'd0);
        send_word(chtbl_pkg::CMD_GET, key_pool[2], 64'd0);
        write_buckets(9'h1ff);
        send_word(chtbl_pkg::CMD_GET, key_pool[0], 64'd0);
        write_buckets(9'd1);
        // Build one long chain in the single bucket, then look up and unlink along it.
        for (int i = 0; i < 120; i++) send_word(chtbl_pkg::CMD_SET, 64'(i) << 40, 64'(i));
        for (int i = 0; i < 120; i += 12) send_word(chtbl_pkg::CMD_GET, 64'(i) << 40, 64'd0);
        for (int i = 0; i < 120; i += 6) send_word(chtbl_pkg::CMD_REMOVE, 64'(i) << 40, 64'd0);
        drain();
        write_buckets(9'd256);
        send_idle_pct = 17;
        random_words(190);
        drain();
        write_buckets(9'd7);
        send_idle_pct = 85;
        random_words(190);
        write_buckets(9'd200);
        send_idle_pct = 0;
        random_words(190);
        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/chtbl_pkg.sv
rtl/chtbl_ram.sv
rtl/chtbl_ctrl.sv
rtl/chtbl_dp.sv
rtl/chained_hash_key_value_table_unit.sv
sim/chained_hash_key_value_table_checker.sv
sim/chained_hash_key_value_table_unit_tb.sv
